// ===== rtl/core/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// Used by tcw_cursor and text_console_writer_unit; no dependencies.
package tcw_pkg;

    localparam int COL_W  = 8;
    localparam int ROW_W  = 6;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;
    localparam int CMD_W  = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUT_CHAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_CELL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ_CELL  = 2'd3;

    // Control characters handled by put char, and the blank used to fill cells.
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    // Clears the low three bits of a widened column (tab stops every 8).
    localparam logic [COL_W:0] TAB_MASK = 9'h1F8;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             wr_cell;
        logic             scroll;
    } t_cursor_next;

endpackage

// ===== rtl/core/text_console_writer_unit.sv =====
// Text console writer top level: command sequencer, address unit and cell RAM.
// Depends on tcw_pkg, tcw_ram and tcw_cursor.
//
// Usage: a command item is taken at a rising edge where start is high and
// busy is low. The command selects put char at the cursor, write cell at a
// position, clear screen, or read cell. Exactly one result item follows,
// shown for one cycle with o_done high: the cursor after the command, the
// scroll flag and, for a read, the cell value (zero otherwise).
// Before o_done the item passes an address step and an execute step; a read
// cell then waits for the registered RAM read, clear screen fills every cell,
// and a put char that scrolls runs one pass that copies each row up, one cell
// per cycle, then blanks the bottom row. busy drops in the cycle after
// o_done, so the next item can be taken in the cycle after the result.
// The receiver cannot stall: results are never held.
// After reset the block runs a clearing pass that zeroes all COLS*ROWS cells
// (2000 at the default size); busy is high meanwhile.
module text_console_writer_unit #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [tcw_pkg::CMD_W-1:0]    i_command,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_attribute,
    input  logic [tcw_pkg::COL_W-1:0]    i_pos_col,
    input  logic [tcw_pkg::ROW_W-1:0]    i_pos_row,
    output logic                         o_done,
    output logic [tcw_pkg::COL_W-1:0]    o_cur_col,
    output logic [tcw_pkg::ROW_W-1:0]    o_cur_row,
    output logic                         o_scrolled,
    output logic [tcw_pkg::CELL_W-1:0]   o_cell_value
);
    import tcw_pkg::*;

    localparam int NCELLS = COLS * ROWS;
    localparam int AW     = $clog2(NCELLS);
    localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);
    localparam logic [AW-1:0] COPY_END  = AW'(NCELLS - COLS);

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_ADDR = 3'd2;
    localparam logic [2:0] ST_EXEC = 3'd3;
    localparam logic [2:0] ST_COPY = 3'd4;
    localparam logic [2:0] ST_FILL = 3'd5;
    localparam logic [2:0] ST_READ = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0]        r_state,  n_state;
    logic [CMD_W-1:0]  r_cmd,    n_cmd;
    logic [CHAR_W-1:0] r_char,   n_char;
    logic [CHAR_W-1:0] r_attr,   n_attr;
    logic [COL_W-1:0]  r_pcol,   n_pcol;
    logic [ROW_W-1:0]  r_prow,   n_prow;
    logic [COL_W-1:0]  r_col,    n_col;
    logic [ROW_W-1:0]  r_row,    n_row;
    logic [AW-1:0]     r_addr,   n_addr;
    logic [AW-1:0]     r_cnt,    n_cnt;
    logic [AW-1:0]     r_wp,     n_wp;
    logic              r_cp_vld, n_cp_vld;
    logic [CELL_W-1:0] r_fill,   n_fill;
    logic              r_scroll, n_scroll;
    logic [CELL_W-1:0] r_value,  n_value;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    t_cursor_next      cur_next;
    logic              pos_inside;
    logic [ROW_W-1:0]  addr_row;
    logic [COL_W-1:0]  addr_col;
    logic [AW:0]       copy_src;

    tcw_cursor #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_cursor (
        .i_col  (r_col),
        .i_row  (r_row),
        .i_char (r_char),
        .o_next (cur_next)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (NCELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign pos_inside = ({1'b0, r_pcol} < 9'(COLS)) && ({1'b0, r_prow} < 7'(ROWS));
    assign addr_row   = (r_cmd == CMD_PUT_CHAR) ? r_row : r_prow;
    assign addr_col   = (r_cmd == CMD_PUT_CHAR) ? r_col : r_pcol;
    assign copy_src   = {1'b0, r_cnt} + (AW + 1)'(COLS);

    // RAM port steering.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt;
        ram_wdata = r_fill;
        ram_re    = 1'b0;
        ram_raddr = r_addr;
        case (r_state)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            ST_EXEC: begin
                ram_waddr = r_addr;
                ram_wdata = {r_attr, r_char};
                if (r_cmd == CMD_PUT_CHAR) begin
                    ram_we = cur_next.wr_cell;
                end else if (r_cmd == CMD_WRITE_CELL) begin
                    ram_we = pos_inside;
                end else if (r_cmd == CMD_READ_CELL) begin
                    ram_re = pos_inside;
                end
            end
            ST_COPY: begin
                // Read one row below, write the cell returned by the previous read.
                ram_re    = (r_cnt < COPY_END);
                ram_raddr = copy_src[AW-1:0];
                ram_we    = r_cp_vld;
                ram_waddr = r_wp;
                ram_wdata = ram_rdata;
            end
            ST_FILL: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_char   = r_char;
        n_attr   = r_attr;
        n_pcol   = r_pcol;
        n_prow   = r_prow;
        n_col    = r_col;
        n_row    = r_row;
        n_addr   = r_addr;
        n_cnt    = r_cnt;
        n_wp     = r_cnt;
        n_cp_vld = 1'b0;
        n_fill   = r_fill;
        n_scroll = r_scroll;
        n_value  = r_value;
        case (r_state)
            ST_INIT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_CELL) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_cmd    = i_command;
                    n_char   = i_char_code;
                    n_attr   = i_attribute;
                    n_pcol   = i_pos_col;
                    n_prow   = i_pos_row;
                    n_scroll = 1'b0;
                    n_value  = '0;
                    n_state  = ST_ADDR;
                end
            end
            ST_ADDR: begin
                n_addr  = AW'(addr_row * COLS + addr_col);
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_cnt  = '0;
                n_fill = {r_attr, CH_SPACE};
                case (r_cmd)
                    CMD_PUT_CHAR: begin
                        n_col    = cur_next.col;
                        n_row    = cur_next.row;
                        n_scroll = cur_next.scroll;
                        n_state  = cur_next.scroll ? ST_COPY : ST_DONE;
                    end
                    CMD_WRITE_CELL: begin
                        n_state = ST_DONE;
                    end
                    CMD_CLEAR: begin
                        n_state = ST_FILL;
                    end
                    CMD_READ_CELL: begin
                        n_state = pos_inside ? ST_READ : ST_DONE;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_COPY: begin
                n_cp_vld = 1'b1;
                if (r_cnt == COPY_END) begin
                    // Last copy write goes out now; blank the bottom row next.
                    n_state = ST_FILL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FILL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_CELL) begin
                    n_state = ST_DONE;
                end
            end
            ST_READ: begin
                n_value = ram_rdata;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_cnt    <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_cp_vld <= 1'b0;
            r_scroll <= 1'b0;
            r_value  <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_col    <= n_col;
            r_row    <= n_row;
            r_cp_vld <= n_cp_vld;
            r_scroll <= n_scroll;
            r_value  <= n_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_char <= n_char;
        r_attr <= n_attr;
        r_pcol <= n_pcol;
        r_prow <= n_prow;
        r_addr <= n_addr;
        r_wp   <= n_wp;
        r_fill <= n_fill;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_done       = (r_state == ST_DONE);
    assign o_cur_col    = r_col;
    assign o_cur_row    = r_row;
    assign o_scrolled   = r_scroll;
    assign o_cell_value = r_value;

`ifndef SYNTH
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_cursor_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ({1'b0, o_cur_col} < 9'(COLS)) && ({1'b0, o_cur_row} < 7'(ROWS)))
        else $error("cursor outside the grid");

    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_scrolled) |-> (o_cur_row == ROW_W'(ROWS - 1)))
        else $error("scroll did not leave the cursor on the bottom row");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy && !o_done)
        else $error("accepted item did not make the block busy");
`endif

endmodule

// ===== rtl/core/tcw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/tcw_cursor.sv =====
// Cursor update for the put-char command: control codes, line wrap, scroll.
// Depends on tcw_pkg.
module tcw_cursor #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic [tcw_pkg::COL_W-1:0]  i_col,
    input  logic [tcw_pkg::ROW_W-1:0]  i_row,
    input  logic [tcw_pkg::CHAR_W-1:0] i_char,
    output tcw_pkg::t_cursor_next      o_next
);
    import tcw_pkg::*;

    // One extra bit each so that a wrap or a step past the last row shows up.
    logic [COL_W:0] x;
    logic [ROW_W:0] y;
    logic           wr;
    logic           scr;

    always_comb begin
        x   = {1'b0, i_col};
        y   = {1'b0, i_row};
        wr  = 1'b0;
        scr = 1'b0;
        case (i_char)
            CH_NEWLINE: begin
                x = '0;
                y = y + 7'd1;
            end
            CH_RETURN: begin
                x = '0;
            end
            CH_BACKSPACE: begin
                if (x != '0) begin
                    x = x - 9'd1;
                end
            end
            CH_TAB: begin
                x = (x + 9'd8) & TAB_MASK;
            end
            default: begin
                wr = 1'b1;
                x  = x + 9'd1;
            end
        endcase
        if (x >= 9'(COLS)) begin
            x = '0;
            y = y + 7'd1;
        end
        if (y >= 7'(ROWS)) begin
            scr = 1'b1;
            y   = 7'(ROWS - 1);
        end
        o_next.col     = x[COL_W-1:0];
        o_next.row     = y[ROW_W-1:0];
        o_next.wr_cell = wr;
        o_next.scroll  = scr;
    end

endmodule
